// ===== design/assert_macros.svh =====
// assertion macros shared by the sorter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SRT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sorter assertion failed");

// expression must never be true outside reset
`define SRT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sorter forbidden condition");

`endif

// ===== design/srt_pkg.sv =====
// shared types and constants of the record sorter
package srt_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int KEY_BITS    = 16;
	localparam int FIELD_W     = 16;
	localparam int KEY_W       = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;

	typedef struct packed {
		logic               vld;
		logic [KEY_W-1:0]   key;
		logic [FIELD_W-1:0] id;
	} rec_t;

	typedef struct packed {
		logic ins;
		logic shl;
	} ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

// ===== design/sort_records_by_capacity.sv =====
// top level of the record sorter: insertion chain, run control and output
// Records are loaded one beat per cycle into a chain of MAX_ENTRIES cells that
// keeps them in ascending capacity order as they arrive (equal keys in load
// order). The beat marked final_record is stored like the others, then the
// chain drains from its head at one sorted beat per cycle while sort_stall is
// low. load_stall is high for the whole drain. A record that arrives while all
// cells are occupied is dropped and overflowed is raised on every beat of that
// run. After the end_of_run beat is taken the chain is empty and the next set
// may load at once.
`include "assert_macros.svh"

module sort_records_by_capacity (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load_valid,
	output logic        load_stall,
	input  logic [15:0] capacity,
	input  logic [15:0] record_id,
	input  logic        final_record,
	output logic        sort_valid,
	input  logic        sort_stall,
	output logic [15:0] sorted_capacity,
	output logic [15:0] sorted_id,
	output logic        end_of_run,
	output logic        overflowed
);

	localparam int N = srt_pkg::MAX_ENTRIES;

	srt_pkg::state_t state_q;
	logic            drop_q;
	srt_pkg::ctl_t   ctl;
	srt_pkg::rec_t   new_rec;
	srt_pkg::rec_t   cell_rec [N];
	logic [N-1:0]    cell_keep;
	logic [N-1:0]    vld_vec;
	logic            load_acc;
	logic            sort_acc;
	logic            full;

	assign load_stall = (state_q == srt_pkg::ST_DRAIN);
	assign load_acc   = load_valid && !load_stall;
	assign sort_valid = (state_q == srt_pkg::ST_DRAIN);
	assign sort_acc   = sort_valid && !sort_stall;
	assign full       = cell_rec[N-1].vld;

	assign ctl.ins = load_acc && !full;
	assign ctl.shl = sort_acc;

	assign new_rec = '{vld: 1'b1, key: capacity[srt_pkg::KEY_W-1:0], id: record_id};

	for (genvar i = 0; i < N; i++) begin : g_cell
		srt_pkg::rec_t left_rec;
		srt_pkg::rec_t right_rec;
		logic          left_keep;

		if (i == 0) begin : g_head
			assign left_rec  = '0;
			assign left_keep = 1'b1;
		end else begin : g_body
			assign left_rec  = cell_rec[i-1];
			assign left_keep = cell_keep[i-1];
		end

		if (i == N-1) begin : g_tail
			assign right_rec = '0;
		end else begin : g_inner
			assign right_rec = cell_rec[i+1];
		end

		srt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_rec   (new_rec),
			.left_rec  (left_rec),
			.left_keep (left_keep),
			.right_rec (right_rec),
			.rec       (cell_rec[i]),
			.keep      (cell_keep[i])
		);

		assign vld_vec[i] = cell_rec[i].vld;
	end

	assign sorted_capacity = srt_pkg::FIELD_W'(cell_rec[0].key);
	assign sorted_id       = cell_rec[0].id;
	assign end_of_run      = !cell_rec[1].vld;
	assign overflowed      = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srt_pkg::ST_LOAD;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				srt_pkg::ST_LOAD: begin
					if (load_acc && full) begin
						drop_q <= 1'b1;
					end
					if (load_acc && final_record) begin
						state_q <= srt_pkg::ST_DRAIN;
					end
				end
				srt_pkg::ST_DRAIN: begin
					if (sort_acc && end_of_run) begin
						state_q <= srt_pkg::ST_LOAD;
						drop_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= srt_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// occupied cells always form an unbroken run from the head
	`SRT_ASSERT(a_contig, clk, arst_n, $onehot({1'b0, vld_vec} + (N+1)'(1)))
	// a drain beat always has a record at the head
	`SRT_NEVER(a_drain_head, clk, arst_n, sort_valid && !vld_vec[0])
	// the chain is empty once the end of the run is taken
	`SRT_ASSERT(a_run_empty, clk, arst_n, sort_acc && end_of_run |=> !vld_vec[0])

endmodule

// ===== design/srt_cell.sv =====
// one cell of the insertion chain: holds one record, inserts or shifts
module srt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  srt_pkg::ctl_t ctl,
	input  srt_pkg::rec_t new_rec,
	input  srt_pkg::rec_t left_rec,
	input  logic          left_keep,
	input  srt_pkg::rec_t right_rec,
	output srt_pkg::rec_t rec,
	output logic          keep
);

	logic                        vld_q;
	logic [srt_pkg::KEY_W-1:0]   key_q;
	logic [srt_pkg::FIELD_W-1:0] id_q;
	logic                        take_new;
	logic                        take_left;

	// equal keys stay ahead of the new record
	assign keep      = vld_q && (key_q <= new_rec.key);
	assign take_new  = ctl.ins && !keep && left_keep;
	assign take_left = ctl.ins && !keep && !left_keep;

	assign rec = '{vld: vld_q, key: key_q, id: id_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take_new) begin
			vld_q <= 1'b1;
		end else if (take_left) begin
			vld_q <= left_rec.vld;
		end else if (ctl.shl) begin
			vld_q <= right_rec.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			key_q <= new_rec.key;
			id_q  <= new_rec.id;
		end else if (take_left) begin
			key_q <= left_rec.key;
			id_q  <= left_rec.id;
		end else if (ctl.shl) begin
			key_q <= right_rec.key;
			id_q  <= right_rec.id;
		end
	end

endmodule

// ===== bench/sort_run_checker.sv =====
// checker for the record sorter: predicts each sorted run and compares every output beat
module sort_run_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load_valid,
	input  logic        load_stall,
	input  logic [15:0] capacity,
	input  logic [15:0] record_id,
	input  logic        final_record,
	input  logic        sort_valid,
	input  logic        sort_stall,
	input  logic [15:0] sorted_capacity,
	input  logic [15:0] sorted_id,
	input  logic        end_of_run,
	input  logic        overflowed,
	output int          fail_count,
	output int          open_count,
	output int          beats_checked
);

	localparam int          DEPTH    = srt_pkg::MAX_ENTRIES;
	localparam logic [15:0] KEY_MASK = 16'((32'h1 << srt_pkg::KEY_W) - 1);

	typedef struct packed {
		logic [15:0] key;
		logic [15:0] id;
		logic        last;
		logic        ovf;
	} sorted_beat_t;

	sorted_beat_t sorted_due[$];
	sorted_beat_t want;
	sorted_beat_t beat;
	logic [15:0]  key_mem [DEPTH];
	logic [15:0]  id_mem  [DEPTH];
	logic [15:0]  hold_key;
	logic [15:0]  hold_id;
	int           fill;
	int           slot;
	logic         dropped;
	int           fails   = 0;
	int           checked = 0;

	assign fail_count    = fails;
	assign open_count    = sorted_due.size();
	assign beats_checked = checked;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_due.delete();
			fill    = 0;
			dropped = 1'b0;
		end else begin
			if (sort_valid && !sort_stall) begin
				if (sorted_due.size() == 0) begin
					$error("sorted beat with nothing due: capacity %0d id %0d",
						sorted_capacity, sorted_id);
					fails++;
				end else begin
					want = sorted_due.pop_front();
					checked++;
					if (sorted_capacity !== want.key) begin
						$error("sorted_capacity: expected %0d, actual %0d",
							want.key, sorted_capacity);
						fails++;
					end
					if (sorted_id !== want.id) begin
						$error("sorted_id: expected %0d, actual %0d", want.id, sorted_id);
						fails++;
					end
					if (end_of_run !== want.last) begin
						$error("end_of_run: expected %0b, actual %0b", want.last, end_of_run);
						fails++;
					end
					if (overflowed !== want.ovf) begin
						$error("overflowed: expected %0b, actual %0b", want.ovf, overflowed);
						fails++;
					end
				end
			end
			if (load_valid && !load_stall) begin
				if (fill < DEPTH) begin
					key_mem[fill] = capacity & KEY_MASK;
					id_mem[fill]  = record_id;
					fill++;
				end else begin
					dropped = 1'b1;
				end
				if (final_record) begin
					// stable insertion sort, equal keys keep load order
					for (int i = 1; i < fill; i++) begin
						hold_key = key_mem[i];
						hold_id  = id_mem[i];
						slot     = i;
						while (slot > 0 && key_mem[slot-1] > hold_key) begin
							key_mem[slot] = key_mem[slot-1];
							id_mem[slot]  = id_mem[slot-1];
							slot--;
						end
						key_mem[slot] = hold_key;
						id_mem[slot]  = hold_id;
					end
					for (int i = 0; i < fill; i++) begin
						beat.key  = key_mem[i];
						beat.id   = id_mem[i];
						beat.last = (i == fill - 1);
						beat.ovf  = dropped;
						sorted_due.insert(sorted_due.size(), beat);
					end
					fill    = 0;
					dropped = 1'b0;
				end
			end
		end
	end

endmodule

// ===== bench/tb_sort_records_by_capacity.sv =====
// testbench top for the record sorter: clock, reset, record stimulus, watchdog and verdict
module tb_sort_records_by_capacity;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_ITEMS   = 360;
	localparam int DRAIN_CYCLES   = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        load_valid;
	logic        load_stall;
	logic [15:0] capacity;
	logic [15:0] record_id;
	logic        final_record;
	logic        sort_valid;
	logic        sort_stall;
	logic [15:0] sorted_capacity;
	logic [15:0] sorted_id;
	logic        end_of_run;
	logic        overflowed;

	int   fail_count;
	int   open_count;
	int   beats_checked;
	int   items_sent    = 0;
	int   sets_sent     = 0;
	int   overfull_sets = 0;
	int   quiet_cycles  = 0;
	logic calm          = 1'b0;

	sort_records_by_capacity uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.load_valid      (load_valid),
		.load_stall      (load_stall),
		.capacity        (capacity),
		.record_id       (record_id),
		.final_record    (final_record),
		.sort_valid      (sort_valid),
		.sort_stall      (sort_stall),
		.sorted_capacity (sorted_capacity),
		.sorted_id       (sorted_id),
		.end_of_run      (end_of_run),
		.overflowed      (overflowed)
	);

	sort_run_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.load_valid      (load_valid),
		.load_stall      (load_stall),
		.capacity        (capacity),
		.record_id       (record_id),
		.final_record    (final_record),
		.sort_valid      (sort_valid),
		.sort_stall      (sort_stall),
		.sorted_capacity (sorted_capacity),
		.sorted_id       (sorted_id),
		.end_of_run      (end_of_run),
		.overflowed      (overflowed),
		.fail_count      (fail_count),
		.open_count      (open_count),
		.beats_checked   (beats_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		sort_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 38);
	end

	always @(posedge clk) begin
		if ((load_valid && !load_stall) || (sort_valid && !sort_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_record(input logic [15:0] cap, input logic [15:0] rid, input logic fin);
		if (!calm) begin
			while ($urandom_range(0, 99) < 38) begin
				load_valid <= 1'b0;
				@(posedge clk);
			end
		end
		load_valid   <= 1'b1;
		capacity     <= cap;
		record_id    <= rid;
		final_record <= fin;
		@(posedge clk);
		while (load_stall) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [15:0] pick_capacity();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(0, 3));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_set(input int count);
		for (int i = 0; i < count; i++) begin
			send_record(pick_capacity(), 16'($urandom()), i == count - 1);
		end
		sets_sent++;
		if (count > srt_pkg::MAX_ENTRIES) overfull_sets++;
	endtask

	initial begin
		int set_size;
		int set_idx;
		arst_n       <= 1'b0;
		load_valid   <= 1'b0;
		capacity     <= 16'h0000;
		record_id    <= 16'h0000;
		final_record <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single record at the top of the key range
		send_record(16'hFFFF, 16'h0000, 1'b1);
		// extremes with ties at both ends
		send_record(16'h0000, 16'hFFFF, 1'b0);
		send_record(16'hFFFF, 16'h0001, 1'b0);
		send_record(16'h0000, 16'h0002, 1'b0);
		send_record(16'h8000, 16'hAAAA, 1'b0);
		send_record(16'hFFFF, 16'h5555, 1'b1);
		// descending load
		send_record(16'd300, 16'h00FF, 1'b0);
		send_record(16'd200, 16'hFF00, 1'b0);
		send_record(16'd100, 16'h1234, 1'b1);
		// all keys equal
		send_record(16'd7, 16'd10, 1'b0);
		send_record(16'd7, 16'd11, 1'b0);
		send_record(16'd7, 16'd12, 1'b1);
		sets_sent = 4;

		set_idx = 0;
		while (items_sent < TARGET_ITEMS) begin
			calm = (items_sent >= 150) && (items_sent < 230);
			case (set_idx)
				2:       set_size = srt_pkg::MAX_ENTRIES;
				5:       set_size = srt_pkg::MAX_ENTRIES + 1;
				9:       set_size = $urandom_range(srt_pkg::MAX_ENTRIES + 2, 40);
				default: begin
					if ($urandom_range(0, 19) == 0) set_size = $urandom_range(20, 40);
					else set_size = $urandom_range(1, 10);
				end
			endcase
			send_set(set_size);
			set_idx++;
		end
		calm = 1'b0;
		load_valid <= 1'b0;

		while (open_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("loaded %0d records in %0d sets, %0d of them over store depth",
			items_sent, sets_sent, overfull_sets);
		$display("checked %0d sorted beats against the predicted order", beats_checked);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/srt_pkg.sv
design/srt_cell.sv
design/sort_records_by_capacity.sv
bench/sort_run_checker.sv
bench/tb_sort_records_by_capacity.sv
